FILE: rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the line centroid steering block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LCPS_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");
`define LCPS_ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("forbidden condition seen");
`else
`define LCPS_ASSERT(lbl, clk, rstn, prop)
`define LCPS_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

FILE: rtl/lcps_pkg.sv
// Types and constants of the line centroid steering block.
`default_nettype none
package lcps_pkg;

    localparam int PIX_W      = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int CENT_W     = 15;
    localparam int ERR_W      = 16;
    localparam int STEER_W    = 32;
    localparam int GAIN_W     = 24;
    localparam int FRAC_BITS  = 6;

    localparam int QUEUE_DEPTH = 2;

    // register file indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 3'd0,
        CFG_CENTER    = 3'd1,
        CFG_OFFSET    = 3'd2,
        CFG_GAIN_P    = 3'd3,
        CFG_GAIN_I    = 3'd4,
        CFG_GAIN_D    = 3'd5
    } cfg_index_t;

    localparam logic [11:0] THRESHOLD_RST = 12'd410;
    localparam logic [8:0]  CENTER_RST    = 9'd160;
    localparam logic [8:0]  OFFSET_RST    = 9'd0;
    localparam logic [23:0] GAIN_P_RST    = 24'd131;
    localparam logic [23:0] GAIN_I_RST    = 24'd0;
    localparam logic [23:0] GAIN_D_RST    = 24'd1311;

    typedef struct packed {
        logic [11:0] sample_threshold;
        logic [8:0]  center_target;
        logic [8:0]  center_offset;
        logic [23:0] gain_p;
        logic [23:0] gain_i;
        logic [23:0] gain_d;
    } cfg_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_DIVIDE,
        BK_CENT,
        BK_ERROR,
        BK_INTEG,
        BK_MUL_P,
        BK_MUL_I,
        BK_MUL_D,
        BK_SUM,
        BK_EMIT
    } back_state_t;

endpackage
`default_nettype wire

FILE: rtl/line_centroid_pid_steering_unit.sv
// Line-scan centroid and PID steering unit: top level with configuration registers.
//
// Input channel (s_*): one pixel per beat, s_last_pixel marks the frame's last pixel.
// Pixels are accepted at one per cycle while the queue is not full; pixels past
// position PIXELS-1 are dropped. Each frame gives one result beat on the m_*
// channel: centroid (Q.6), line-found, all-lit, line error (Q.6) and the saturated
// Q16.16 PID steering command. Frame summaries wait in a two-entry queue; the back
// end then runs a one-bit-per-cycle centroid divider, then error, integral and
// three passes of one shared 24x32 multiplier. A frame with no lit pixel skips the
// divider. s_ready drops only while the queue holds two unprocessed frames, which
// happens only when frames are shorter than the back-end time or m_ready stalls.
// A stalled m_ready holds the finished result in the output register; the back end
// then waits in its last step and the queue, then s_ready, back up behind it.
// Configuration (cfg_*) is always ready; indexes past the last register are ignored.
// Reset (aresetn low, synchronous) restores register defaults, clears the frame
// accumulators, PID history and both channels.
`default_nettype none
`include "assert_macros.svh"
module line_centroid_pid_steering_unit #(
    parameter int PIXELS = 320
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic [lcps_pkg::PIX_W-1:0]            s_pixel_sample,
    input  wire logic                                  s_last_pixel,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic [lcps_pkg::CENT_W-1:0]                m_centroid_q6,
    output logic                                       m_line_found,
    output logic                                       m_all_lit,
    output logic signed [lcps_pkg::ERR_W-1:0]          m_line_error_q6,
    output logic signed [lcps_pkg::STEER_W-1:0]        m_steering_command,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [lcps_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [lcps_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import lcps_pkg::*;

    localparam int IDX_W = $clog2(PIXELS + 1);
    localparam int CNT_W = $clog2(PIXELS + 1);
    localparam int SUM_W = $clog2(PIXELS * (PIXELS - 1) / 2 + 1);
    localparam int NUM_W = SUM_W + FRAC_BITS + 1;
    localparam int Q_W   = SUM_W + CNT_W + 1;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sample_threshold <= THRESHOLD_RST;
            cfg_reg.center_target    <= CENTER_RST;
            cfg_reg.center_offset    <= OFFSET_RST;
            cfg_reg.gain_p           <= GAIN_P_RST;
            cfg_reg.gain_i           <= GAIN_I_RST;
            cfg_reg.gain_d           <= GAIN_D_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_THRESHOLD: cfg_reg.sample_threshold <= cfg_data[11:0];
                CFG_CENTER:    cfg_reg.center_target    <= cfg_data[8:0];
                CFG_OFFSET:    cfg_reg.center_offset    <= cfg_data[8:0];
                CFG_GAIN_P:    cfg_reg.gain_p           <= cfg_data;
                CFG_GAIN_I:    cfg_reg.gain_i           <= cfg_data;
                CFG_GAIN_D:    cfg_reg.gain_d           <= cfg_data;
                default:       cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    logic             q_push, q_full, q_pop, q_empty;
    logic [SUM_W-1:0] push_sum;
    logic [CNT_W-1:0] push_cnt;
    logic             push_all_lit;
    logic [Q_W-1:0]   q_rd_data;

    lcps_front #(
        .PIXELS (PIXELS),
        .IDX_W  (IDX_W),
        .CNT_W  (CNT_W),
        .SUM_W  (SUM_W)
    ) u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .pixel_sample     (s_pixel_sample),
        .last_pixel       (s_last_pixel),
        .sample_threshold (cfg_reg.sample_threshold),
        .q_full           (q_full),
        .push_valid       (q_push),
        .push_sum         (push_sum),
        .push_cnt         (push_cnt),
        .push_all_lit     (push_all_lit)
    );

    lcps_queue #(
        .W (Q_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data ({push_sum, push_cnt, push_all_lit}),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_data  (q_rd_data)
    );

    lcps_back #(
        .CNT_W (CNT_W),
        .SUM_W (SUM_W),
        .NUM_W (NUM_W)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .q_empty      (q_empty),
        .q_sum        (q_rd_data[Q_W-1 -: SUM_W]),
        .q_cnt        (q_rd_data[CNT_W:1]),
        .q_all_lit    (q_rd_data[0]),
        .q_pop        (q_pop),
        .out_valid    (m_valid),
        .out_ready    (m_ready),
        .out_centroid (m_centroid_q6),
        .out_found    (m_line_found),
        .out_all_lit  (m_all_lit),
        .out_error    (m_line_error_q6),
        .out_steer    (m_steering_command)
    );

    logic no_line_beat;
    logic zero_outputs;

    assign no_line_beat = m_valid && !m_line_found;
    assign zero_outputs = (m_steering_command == '0) && (m_centroid_q6 == '0);

    `LCPS_ASSERT_NEVER(a_push_when_full, aclk, aresetn, q_push && q_full)
    `LCPS_ASSERT_NEVER(a_pop_when_empty, aclk, aresetn, q_pop && q_empty)
    `LCPS_ASSERT(a_no_line_zero_out, aclk, aresetn, no_line_beat |-> zero_outputs)

endmodule
`default_nettype wire

FILE: rtl/lcps_front.sv
// Pixel front end: threshold and per-frame index sum, count and all-lit tracking.
`default_nettype none
module lcps_front #(
    parameter int PIXELS = 320,
    parameter int IDX_W  = 9,
    parameter int CNT_W  = 9,
    parameter int SUM_W  = 16
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [lcps_pkg::PIX_W-1:0]  pixel_sample,
    input  wire logic                        last_pixel,
    input  wire logic [lcps_pkg::PIX_W-1:0]  sample_threshold,
    input  wire logic                        q_full,
    output logic                             push_valid,
    output logic [SUM_W-1:0]                 push_sum,
    output logic [CNT_W-1:0]                 push_cnt,
    output logic                             push_all_lit
);
    import lcps_pkg::*;

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             all_reg, all_next;
    logic             accept;
    logic             lit;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign lit     = pixel_sample > sample_threshold;

    // pixels past the frame length are dropped; index saturates at PIXELS
    always_comb begin
        idx_next = idx_reg;
        sum_next = sum_reg;
        cnt_next = cnt_reg;
        all_next = all_reg;
        if (idx_reg < IDX_W'(PIXELS)) begin
            if (lit) begin
                sum_next = sum_reg + SUM_W'(idx_reg);
                cnt_next = cnt_reg + CNT_W'(1);
            end else begin
                all_next = 1'b0;
            end
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    assign push_valid   = accept && last_pixel;
    assign push_sum     = sum_next;
    assign push_cnt     = cnt_next;
    assign push_all_lit = all_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
            sum_reg <= '0;
            cnt_reg <= '0;
            all_reg <= 1'b1;
        end else if (accept) begin
            if (last_pixel) begin
                idx_reg <= '0;
                sum_reg <= '0;
                cnt_reg <= '0;
                all_reg <= 1'b1;
            end else begin
                idx_reg <= idx_next;
                sum_reg <= sum_next;
                cnt_reg <= cnt_next;
                all_reg <= all_next;
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/lcps_queue.sv
// Two-entry frame summary queue between the front end and the PID back end.
`default_nettype none
module lcps_queue #(
    parameter int W = 26
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         push,
    input  wire logic [W-1:0] push_data,
    output logic              full,
    input  wire logic         pop,
    output logic              empty,
    output logic [W-1:0]      pop_data
);
    import lcps_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

    logic [W-1:0]     mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [LVL_W-1:0] level_reg;

    assign full     = level_reg == LVL_W'(QUEUE_DEPTH);
    assign empty    = level_reg == '0;
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + PTR_W'(1);
            end
            case ({push, pop})
                2'b10:   level_reg <= level_reg + LVL_W'(1);
                2'b01:   level_reg <= level_reg - LVL_W'(1);
                default: level_reg <= level_reg;
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: rtl/lcps_back.sv
// Per-frame back end: centroid divider, line error, PID with one shared multiplier.
`default_nettype none
module lcps_back #(
    parameter int CNT_W = 9,
    parameter int SUM_W = 16,
    parameter int NUM_W = 23
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire lcps_pkg::cfg_t                     cfg,
    input  wire logic                               q_empty,
    input  wire logic [SUM_W-1:0]                   q_sum,
    input  wire logic [CNT_W-1:0]                   q_cnt,
    input  wire logic                               q_all_lit,
    output logic                                    q_pop,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [lcps_pkg::CENT_W-1:0]             out_centroid,
    output logic                                    out_found,
    output logic                                    out_all_lit,
    output logic signed [lcps_pkg::ERR_W-1:0]       out_error,
    output logic signed [lcps_pkg::STEER_W-1:0]     out_steer
);
    import lcps_pkg::*;

    localparam int STEP_W = $clog2(NUM_W);
    localparam int PROD_W = GAIN_W + 32;
    localparam int ACC_W  = PROD_W + 2;
    localparam int EW_W   = ERR_W + 2;

    localparam logic signed [ACC_W-1:0] STEER_MAX = {{(ACC_W-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [ACC_W-1:0] STEER_MIN = {{(ACC_W-31){1'b1}}, {31{1'b0}}};
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(32);

    back_state_t state_reg, state_next;

    logic [CNT_W-1:0]         cnt_reg;
    logic [NUM_W-1:0]         num_reg;
    logic [CNT_W-1:0]         rem_reg;
    logic [STEP_W-1:0]        step_reg;
    logic                     found_reg, all_lit_reg;
    logic [CENT_W-1:0]        cent_reg;
    logic signed [ERR_W-1:0]  err_reg;
    logic signed [31:0]       integ_reg;
    logic signed [ERR_W:0]    deriv_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ERR_W-1:0]  prev_err_reg;
    logic signed [31:0]       integral_reg;
    logic                     valid_reg, valid_next;

    logic                     emit_fire;
    logic                     slot_free;

    // one restoring division step per cycle
    logic [CNT_W:0]   div_shift;
    logic [CNT_W+1:0] div_diff;
    logic             div_ge;

    assign div_shift = {rem_reg, num_reg[NUM_W-1]};
    assign div_diff  = {1'b0, div_shift} - {2'b00, cnt_reg};
    assign div_ge    = !div_diff[CNT_W+1];

    logic [31:0] quot_wide;
    assign quot_wide = 32'(num_reg);

    logic signed [EW_W-1:0] err_wide;
    assign err_wide = $signed({3'b000, cfg.center_target, 6'b000000})
                    - $signed({3'b000, cent_reg})
                    + $signed({{3{cfg.center_offset[8]}}, cfg.center_offset, 6'b000000});

    logic signed [32:0] integ_wide;
    assign integ_wide = $signed({integral_reg[31], integral_reg})
                      + $signed({{17{err_reg[ERR_W-1]}}, err_reg});

    // shared multiplier, operands picked by state
    logic signed [GAIN_W-1:0] mul_a;
    logic signed [31:0]       mul_b;
    logic signed [PROD_W-1:0] mul_p;

    always_comb begin
        case (state_reg)
            BK_MUL_I: begin
                mul_a = $signed(cfg.gain_i);
                mul_b = integ_reg;
            end
            BK_MUL_D: begin
                mul_a = $signed(cfg.gain_d);
                mul_b = {{(32-ERR_W-1){deriv_reg[ERR_W]}}, deriv_reg};
            end
            default: begin
                mul_a = $signed(cfg.gain_p);
                mul_b = {{(32-ERR_W){err_reg[ERR_W-1]}}, err_reg};
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    logic signed [ACC_W-1:0] rnd_shift;
    logic signed [STEER_W-1:0] steer_val;
    assign rnd_shift = (acc_reg + ROUND_HALF) >>> FRAC_BITS;

    always_comb begin
        if (!found_reg) begin
            steer_val = '0;
        end else if (rnd_shift > STEER_MAX) begin
            steer_val = STEER_MAX[STEER_W-1:0];
        end else if (rnd_shift < STEER_MIN) begin
            steer_val = STEER_MIN[STEER_W-1:0];
        end else begin
            steer_val = rnd_shift[STEER_W-1:0];
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: begin
                if (!q_empty) begin
                    state_next = (q_cnt == '0) ? BK_CENT : BK_DIVIDE;
                end
            end
            BK_DIVIDE: begin
                if (step_reg == '0) begin
                    state_next = BK_CENT;
                end
            end
            BK_CENT:  state_next = BK_ERROR;
            BK_ERROR: state_next = BK_INTEG;
            BK_INTEG: state_next = BK_MUL_P;
            BK_MUL_P: state_next = BK_MUL_I;
            BK_MUL_I: state_next = BK_MUL_D;
            BK_MUL_D: state_next = BK_SUM;
            BK_SUM:   state_next = BK_EMIT;
            BK_EMIT: begin
                if (slot_free) begin
                    state_next = BK_IDLE;
                end
            end
            default:  state_next = BK_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        q_pop     = 1'b0;
        emit_fire = 1'b0;
        case (state_reg)
            BK_IDLE: q_pop     = !q_empty;
            BK_EMIT: emit_fire = slot_free;
            default: begin
                q_pop     = 1'b0;
                emit_fire = 1'b0;
            end
        endcase
    end

    assign slot_free = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg && !out_ready;
        if (emit_fire) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= BK_IDLE;
            valid_reg    <= 1'b0;
            prev_err_reg <= '0;
            integral_reg <= '0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            if (emit_fire && found_reg) begin
                prev_err_reg <= err_reg;
                integral_reg <= integ_reg;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            BK_IDLE: begin
                cnt_reg     <= q_cnt;
                all_lit_reg <= q_all_lit;
                found_reg   <= q_cnt != '0;
                rem_reg     <= '0;
                step_reg    <= STEP_W'(NUM_W - 1);
                if (q_cnt == '0) begin
                    num_reg <= '0;
                end else begin
                    num_reg <= NUM_W'({q_sum, 6'b000000}) + NUM_W'(q_cnt >> 1);
                end
            end
            BK_DIVIDE: begin
                rem_reg  <= div_ge ? div_diff[CNT_W-1:0] : div_shift[CNT_W-1:0];
                num_reg  <= {num_reg[NUM_W-2:0], div_ge};
                step_reg <= step_reg - STEP_W'(1);
            end
            BK_CENT: begin
                cent_reg <= (quot_wide > 32'd32767) ? {CENT_W{1'b1}} : quot_wide[CENT_W-1:0];
            end
            BK_ERROR: begin
                if (err_wide > EW_W'(32767)) begin
                    err_reg <= 16'sh7FFF;
                end else if (err_wide < -EW_W'(32768)) begin
                    err_reg <= 16'sh8000;
                end else begin
                    err_reg <= err_wide[ERR_W-1:0];
                end
            end
            BK_INTEG: begin
                if (integ_wide[32] != integ_wide[31]) begin
                    integ_reg <= integ_wide[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                end else begin
                    integ_reg <= integ_wide[31:0];
                end
                deriv_reg <= {err_reg[ERR_W-1], err_reg}
                           - {prev_err_reg[ERR_W-1], prev_err_reg};
            end
            BK_MUL_P: prod_reg <= mul_p;
            BK_MUL_I: begin
                prod_reg <= mul_p;
                acc_reg  <= ACC_W'(prod_reg);
            end
            BK_MUL_D: begin
                prod_reg <= mul_p;
                acc_reg  <= acc_reg + ACC_W'(prod_reg);
            end
            BK_SUM:   acc_reg <= acc_reg + ACC_W'(prod_reg);
            BK_EMIT: begin
                if (emit_fire) begin
                    out_centroid <= cent_reg;
                    out_found    <= found_reg;
                    out_all_lit  <= all_lit_reg;
                    out_error    <= err_reg;
                    out_steer    <= steer_val;
                end
            end
            default: begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign out_valid = valid_reg;

endmodule
`default_nettype wire
